// File: hw/rtl/drive_mode_velocity_shaper_defines.svh
// Assertion macros shared by the velocity shaper RTL.
// No dependencies; modules using these must have clk and rst_n in scope.
`ifndef DRIVE_MODE_VELOCITY_SHAPER_DEFINES_SVH
`define DRIVE_MODE_VELOCITY_SHAPER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DMVS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmvs: same-cycle check failed");

// next-cycle implication, disabled in reset
`define DMVS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmvs: next-cycle check failed");

`endif

// File: hw/rtl/dmvs_pkg.sv
// Shared widths, register codes and pipeline side-band types for the shaper.
// No dependencies.
package dmvs_pkg;

    localparam int DATA_W = 32;
    localparam int MODE_W = 2;
    localparam int CTR_W  = 19;
    localparam int RAD_W  = 18;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 19;
    localparam int PROD_W = DATA_W + RAD_W;
    localparam int FRAC_W = 16;

    // quotient bits resolved per divider stage
    localparam int DIV_STEP_DEF = 4;

    localparam logic [MODE_W-1:0] MODE_OMNI    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIFF    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

    localparam logic [IDX_W-1:0] REG_DRIVE_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_X   = 2'd1;
    localparam logic [IDX_W-1:0] REG_MIN_RADIUS = 2'd2;

    localparam logic signed [CTR_W-1:0] CENTER_LIMIT = 19'sd131072;
    localparam logic [RAD_W-1:0]        RADIUS_RESET = 18'd26214;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [CTR_W-1:0] center;
        logic [RAD_W-1:0]        radius;
    } dmvs_cfg_t;

    // command fields and flags that ride along the pipeline
    typedef struct packed {
        logic [DATA_W-1:0] fwd;
        logic [DATA_W-1:0] lat;
        logic [DATA_W-1:0] yaw;
        logic              omni;
        logic              yaw_zero;
        logic              clip;
    } dmvs_side_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rem;
        logic [DATA_W-1:0] dvd;
        logic [DATA_W-1:0] quo;
    } dmvs_div_t;

    typedef struct packed {
        logic [DATA_W-1:0] fwd;
        logic [DATA_W-1:0] lat;
        logic [DATA_W-1:0] yaw;
    } dmvs_res_t;

endpackage

// File: hw/rtl/dmvs_cmd_if.sv
// Command channel: valid/ready with the three input velocity fields.
// Depends on dmvs_pkg.
interface dmvs_cmd_if import dmvs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] vel_fwd;
    logic signed [DATA_W-1:0] vel_lat;
    logic signed [DATA_W-1:0] yaw_rate;

    modport source (output valid, vel_fwd, vel_lat, yaw_rate, input ready);
    modport sink (input valid, vel_fwd, vel_lat, yaw_rate, output ready);
endinterface

// File: hw/rtl/dmvs_res_if.sv
// Result channel: valid/ready with the three shaped velocity fields.
// Depends on dmvs_pkg.
interface dmvs_res_if import dmvs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_fwd;
    logic signed [DATA_W-1:0] out_lat;
    logic signed [DATA_W-1:0] out_yaw;

    modport source (output valid, out_fwd, out_lat, out_yaw, input ready);
    modport sink (input valid, out_fwd, out_lat, out_yaw, output ready);
endinterface

// File: hw/rtl/dmvs_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on dmvs_pkg.
interface dmvs_cfg_if import dmvs_pkg::*;;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/dmvs_cfg_regs.sv
// Configuration registers: drive mode, rotation center x, minimum radius.
// Depends on dmvs_pkg and dmvs_cfg_if.
module dmvs_cfg_regs
    import dmvs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    dmvs_cfg_if.sink        cfg,
    output dmvs_cfg_t       cfg_out
);

    dmvs_cfg_t               cfg_reg;
    dmvs_cfg_t               cfg_next;
    logic signed [CTR_W-1:0] center_wr;

    assign cfg.ready = 1'b1;
    assign center_wr = cfg.data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DRIVE_MODE:
                begin
                    // code 3 is not a mode; keep the old one
                    if (cfg.data[MODE_W-1:0] != MODE_INVALID)
                    begin
                        cfg_next.mode = cfg.data[MODE_W-1:0];
                    end
                end
                REG_CENTER_X:
                begin
                    if (center_wr > CENTER_LIMIT)
                    begin
                        cfg_next.center = CENTER_LIMIT;
                    end
                    else if (center_wr < -CENTER_LIMIT)
                    begin
                        cfg_next.center = -CENTER_LIMIT;
                    end
                    else
                    begin
                        cfg_next.center = center_wr;
                    end
                end
                REG_MIN_RADIUS:
                begin
                    cfg_next.radius = cfg.data[RAD_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= MODE_DIFF;
            cfg_reg.center <= '0;
            cfg_reg.radius <= RADIUS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_out = cfg_reg;

endmodule

// File: hw/rtl/dmvs_front.sv
// Front stages: input register, |vel_fwd| and min_radius*|yaw| product,
// radius test and divider seed. Depends on dmvs_pkg and the defines header.
`include "drive_mode_velocity_shaper_defines.svh"
module dmvs_front
    import dmvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] in_fwd,
    input  logic [DATA_W-1:0] in_lat,
    input  logic [DATA_W-1:0] in_yaw,
    input  dmvs_cfg_t         cfg_in,
    output logic              out_valid,
    output dmvs_side_t        out_side,
    output dmvs_div_t         out_div
);

    // stage 0: input capture
    logic              v0_reg;
    logic [DATA_W-1:0] fwd0_reg, lat0_reg, yaw0_reg;

    // stage 1: magnitudes and product
    logic              v1_reg;
    dmvs_side_t        side1_reg, side1_next;
    logic              ack1_reg, ack1_next;
    logic [DATA_W-1:0] afwd1_reg, afwd1_next;
    logic [PROD_W-1:0] prod1_reg, prod1_next;
    logic [DATA_W-1:0] ayaw1;

    // stage 2: compare and divider seed
    logic              v2_reg;
    dmvs_side_t        side2_reg, side2_next;
    dmvs_div_t         div2_reg, div2_next;
    logic              clip2;

    always_comb
    begin
        afwd1_next = fwd0_reg[DATA_W-1] ? (DATA_W'(0) - fwd0_reg) : fwd0_reg;
        ayaw1      = yaw0_reg[DATA_W-1] ? (DATA_W'(0) - yaw0_reg) : yaw0_reg;
        prod1_next = PROD_W'(ayaw1) * PROD_W'(cfg_in.radius);

        side1_next.fwd      = fwd0_reg;
        side1_next.lat      = lat0_reg;
        side1_next.yaw      = yaw0_reg;
        side1_next.omni     = (cfg_in.mode == MODE_OMNI);
        side1_next.yaw_zero = (yaw0_reg == '0);
        side1_next.clip     = 1'b0;
        ack1_next = (cfg_in.mode == MODE_ACK) && (cfg_in.radius != '0);
    end

    always_comb
    begin
        // |fwd|*2^16 below radius*|yaw|: the quotient fits in 31 bits
        clip2 = ack1_reg && !side1_reg.yaw_zero
             && ({2'b00, afwd1_reg, 16'h0000} < prod1_reg);
        side2_next      = side1_reg;
        side2_next.clip = clip2;
        // dividend is |fwd|<<16; top 16 bits seed the remainder
        div2_next.rem = clip2 ? RAD_W'(afwd1_reg[DATA_W-1:FRAC_W]) : '0;
        div2_next.dvd = {afwd1_reg[FRAC_W-1:0], 16'h0000};
        div2_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fwd0_reg  <= in_fwd;
            lat0_reg  <= in_lat;
            yaw0_reg  <= in_yaw;
            side1_reg <= side1_next;
            ack1_reg  <= ack1_next;
            afwd1_reg <= afwd1_next;
            prod1_reg <= prod1_next;
            side2_reg <= side2_next;
            div2_reg  <= div2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_side  = side2_reg;
    assign out_div   = div2_reg;

    `DMVS_ASSERT_IMP(a_clip_not_omni, v2_reg && side2_reg.clip, !side2_reg.omni)
    `DMVS_ASSERT_IMP(a_seed_below_radius, v2_reg && side2_reg.clip,
                     div2_reg.rem < cfg_in.radius)
    `DMVS_ASSERT_IMP(a_zero_yaw_no_clip, v2_reg && side2_reg.yaw_zero, !side2_reg.clip)

endmodule

// File: hw/rtl/dmvs_div_stage.sv
// One registered restoring-divider stage, DIV_STEP quotient bits per cycle while en is high.
// Depends on dmvs_pkg and the defines header.
`include "drive_mode_velocity_shaper_defines.svh"
module dmvs_div_stage
    import dmvs_pkg::*;
#(
    parameter int DIV_STEP = DIV_STEP_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [RAD_W-1:0] radius,
    input  logic             in_valid,
    input  dmvs_side_t       in_side,
    input  dmvs_div_t        in_div,
    output logic             out_valid,
    output dmvs_side_t       out_side,
    output dmvs_div_t        out_div
);

    logic       v_reg;
    dmvs_side_t side_reg;
    dmvs_div_t  div_reg, div_next;

    always_comb
    begin
        logic [RAD_W:0] trial;
        div_next = in_div;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial = {div_next.rem, div_next.dvd[DATA_W-1]};
            div_next.dvd = {div_next.dvd[DATA_W-2:0], 1'b0};
            if (trial >= {1'b0, radius})
            begin
                trial        = trial - {1'b0, radius};
                div_next.quo = {div_next.quo[DATA_W-2:0], 1'b1};
            end
            else
            begin
                div_next.quo = {div_next.quo[DATA_W-2:0], 1'b0};
            end
            div_next.rem = trial[RAD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            div_reg  <= div_next;
        end
    end

    assign out_valid = v_reg;
    assign out_side  = side_reg;
    assign out_div   = div_reg;

    `DMVS_ASSERT_IMP(a_rem_bound, v_reg && side_reg.clip, div_reg.rem < radius)
    `DMVS_ASSERT_IMP(a_quo_room, in_valid && in_side.clip, in_div.quo[DATA_W-1] == 1'b0)

endmodule

// File: hw/rtl/dmvs_back.sv
// Back stages: clipped yaw select, yaw*center product, lateral saturation
// and the output register. Depends on dmvs_pkg and the defines header.
`include "drive_mode_velocity_shaper_defines.svh"
module dmvs_back
    import dmvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic signed [CTR_W-1:0] center,
    input  logic              in_valid,
    input  dmvs_side_t        in_side,
    input  logic [DATA_W-1:0] in_quo,
    output logic              out_valid,
    output dmvs_res_t         out_res
);

    localparam logic [PROD_W-FRAC_W-1:0] POS_MAX = (PROD_W-FRAC_W)'(32'h7FFF_FFFF);
    localparam logic [PROD_W-FRAC_W-1:0] NEG_MAX = (PROD_W-FRAC_W)'(32'h8000_0000);

    // stage A: shaped yaw and its magnitude
    logic              va_reg;
    dmvs_side_t        sa_reg, sa_next;
    logic [DATA_W-1:0] maga_reg, maga_next;

    // stage B: lateral product
    logic              vb_reg;
    dmvs_side_t        sb_reg;
    logic              negb_reg, negb_next;
    logic [PROD_W-1:0] prodb_reg, prodb_next;
    logic [RAD_W-1:0]  actr;

    // stage C: output register
    logic              vo_reg;
    dmvs_res_t         res_reg, res_next;
    logic [PROD_W-FRAC_W-1:0] lat_mag;
    logic [DATA_W-1:0] lat_sat;

    always_comb
    begin
        sa_next = in_side;
        if (in_side.clip)
        begin
            sa_next.yaw = in_side.yaw[DATA_W-1] ? (DATA_W'(0) - in_quo) : in_quo;
            maga_next   = in_quo;
        end
        else
        begin
            maga_next = in_side.yaw[DATA_W-1] ? (DATA_W'(0) - in_side.yaw) : in_side.yaw;
        end
    end

    always_comb
    begin
        actr       = center[CTR_W-1] ? RAD_W'(-center) : RAD_W'(center);
        prodb_next = PROD_W'(maga_reg) * PROD_W'(actr);
        // product is negated unless exactly one factor is negative
        negb_next  = (sa_reg.yaw[DATA_W-1] == center[CTR_W-1]);
    end

    always_comb
    begin
        lat_mag = prodb_reg[PROD_W-1:FRAC_W];
        if (negb_reg)
        begin
            lat_sat = (lat_mag > NEG_MAX) ? 32'h8000_0000
                                          : (DATA_W'(0) - lat_mag[DATA_W-1:0]);
        end
        else
        begin
            lat_sat = (lat_mag > POS_MAX) ? 32'h7FFF_FFFF : lat_mag[DATA_W-1:0];
        end
        res_next.fwd = sb_reg.fwd;
        res_next.yaw = sb_reg.yaw;
        if (sb_reg.omni)
        begin
            res_next.lat = sb_reg.lat;
        end
        else if (sb_reg.yaw_zero)
        begin
            res_next.lat = '0;
        end
        else
        begin
            res_next.lat = lat_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vo_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg    <= sa_next;
            maga_reg  <= maga_next;
            sb_reg    <= sa_reg;
            negb_reg  <= negb_next;
            prodb_reg <= prodb_next;
            res_reg   <= res_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_res   = res_reg;

    `DMVS_ASSERT_IMP(a_zero_yaw_product, vb_reg && sb_reg.yaw_zero, prodb_reg == '0)
    `DMVS_ASSERT_IMP(a_clip_shrinks, va_reg && sa_reg.clip,
                     maga_reg[DATA_W-1] == 1'b0)
    `DMVS_ASSERT_IMP(a_stage_c_zero, vb_reg && en && !sb_reg.omni && sb_reg.yaw_zero,
                     res_next.lat == '0 && res_next.yaw == '0)

endmodule

// File: hw/rtl/drive_mode_velocity_shaper.sv
// Path: a command passes through 3 front stages, 32/DIV_STEP divider stages and
// 3 back stages before its result shows on the output.
// Throughput: one command per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset: rst_n clears all valid bits; mode resets to differential, center to 0,
// minimum radius to 0.4. Config writes are taken every cycle.
`include "drive_mode_velocity_shaper_defines.svh"
module drive_mode_velocity_shaper
    import dmvs_pkg::*;
#(
    parameter int DIV_STEP = DIV_STEP_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    dmvs_cmd_if.sink cmd,
    dmvs_res_if.source res,
    dmvs_cfg_if.sink cfg
);

    localparam int DIV_STAGES = DATA_W / DIV_STEP;

    logic       en;
    dmvs_cfg_t  cfg_cur;
    logic       dv   [DIV_STAGES+1];
    dmvs_side_t dside[DIV_STAGES+1];
    dmvs_div_t  ddiv [DIV_STAGES+1];
    logic       res_valid;
    dmvs_res_t  res_data;

    // global advance: output register empty or being drained
    assign en        = !res_valid || res.ready;
    assign cmd.ready = en;

    dmvs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    dmvs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cmd.valid),
        .in_fwd    (cmd.vel_fwd),
        .in_lat    (cmd.vel_lat),
        .in_yaw    (cmd.yaw_rate),
        .cfg_in    (cfg_cur),
        .out_valid (dv[0]),
        .out_side  (dside[0]),
        .out_div   (ddiv[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        dmvs_div_stage #(
            .DIV_STEP (DIV_STEP)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .radius    (cfg_cur.radius),
            .in_valid  (dv[g]),
            .in_side   (dside[g]),
            .in_div    (ddiv[g]),
            .out_valid (dv[g+1]),
            .out_side  (dside[g+1]),
            .out_div   (ddiv[g+1])
        );
    end

    dmvs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .center    (cfg_cur.center),
        .in_valid  (dv[DIV_STAGES]),
        .in_side   (dside[DIV_STAGES]),
        .in_quo    (ddiv[DIV_STAGES].quo),
        .out_valid (res_valid),
        .out_res   (res_data)
    );

    assign res.valid   = res_valid;
    assign res.out_fwd = res_data.fwd;
    assign res.out_lat = res_data.lat;
    assign res.out_yaw = res_data.yaw;

    `DMVS_ASSERT_IMP(a_stall_blocks_cmd, res.valid && !res.ready, !cmd.ready)
    `DMVS_ASSERT_NXT(a_held_result, res.valid && !res.ready, res.valid)
    `DMVS_ASSERT_IMP(a_ready_when_empty, !res.valid, cmd.ready)

endmodule

// File: tb/testbench.sv
// Self-checking bench for drive_mode_velocity_shaper: directed corners, back-pressure,
// then randomized commands over many register settings, checked against a local predictor.
// Depends on dmvs_pkg, the dmvs_cmd_if / dmvs_res_if / dmvs_cfg_if interfaces and the RTL.
`timescale 1ns / 100ps

module testbench;
    import dmvs_pkg::*;

    localparam logic [IDX_W-1:0]  REG_SPARE    = 2'd3;
    localparam int  IDLE_PCT      = 22;
    localparam int  HOLD_CYCLES   = 300;
    localparam int  STALL_LIMIT   = 3000;
    localparam int  DRAIN_CYCLES  = 40;
    localparam int  PHASES        = 12;
    localparam int  PHASE_ITEMS   = 115;
    localparam longint LAT_MAX    = 64'sd2147483647;
    localparam longint LAT_MIN    = -64'sd2147483648;

    logic clk;
    logic rst_n;

    dmvs_cmd_if cmd_bus ();
    dmvs_res_if res_bus ();
    dmvs_cfg_if cfg_bus ();

    drive_mode_velocity_shaper dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    // shadow copy of the block's registers
    logic [MODE_W-1:0]       mode_q;
    logic signed [CTR_W-1:0] center_q;
    logic [RAD_W-1:0]        radius_q;

    dmvs_res_t shaped_q[$];

    bit src_idle_en;
    bit sink_idle_en;
    bit hold_request;
    int hold_left;
    int stall_cycles;
    int fail_count;
    int commands_sent;
    int results_checked;
    int cfg_writes;
    int clip_count;
    int lat_sat_count;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // predicted result for one command under the current register settings
    function automatic dmvs_res_t shape_command(input logic [DATA_W-1:0] fwd_in,
                                                input logic [DATA_W-1:0] lat_in,
                                                input logic [DATA_W-1:0] yaw_in);
        longint fwd;
        longint yaw;
        longint ctr;
        longint lat;
        longint unsigned afwd;
        longint unsigned ayaw;
        longint unsigned quo;
        longint unsigned prod;
        dmvs_res_t r;
        fwd = $signed(fwd_in);
        yaw = $signed(yaw_in);
        ctr = center_q;
        r.fwd = fwd_in;
        r.lat = lat_in;
        r.yaw = yaw_in;
        if (mode_q != MODE_OMNI)
        begin
            if (yaw == 0)
            begin
                r.lat = '0;
            end
            else
            begin
                if (mode_q == MODE_ACK && radius_q != '0)
                begin
                    afwd = ((fwd < 0) ? -fwd : fwd) << 16;
                    ayaw = (yaw < 0) ? -yaw : yaw;
                    // turning radius below minimum: scale yaw down, keep its sign
                    if (afwd < ayaw * radius_q)
                    begin
                        quo = afwd / radius_q;
                        if (quo > ayaw)
                            quo = ayaw;
                        yaw = (yaw < 0) ? -longint'(quo) : longint'(quo);
                        clip_count++;
                    end
                end
                prod = (((yaw < 0) ? -yaw : yaw) * ((ctr < 0) ? -ctr : ctr)) >> 16;
                // lateral = -yaw*center, negative when yaw and center share a sign
                if (prod == 0)
                    lat = 0;
                else if ((yaw < 0) == (ctr < 0))
                    lat = (prod > 64'd2147483648) ? LAT_MIN : -longint'(prod);
                else
                    lat = (prod > 64'd2147483647) ? LAT_MAX : longint'(prod);
                if (lat == LAT_MAX || lat == LAT_MIN)
                    lat_sat_count++;
                r.lat = lat[DATA_W-1:0];
                r.yaw = yaw[DATA_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic send_command(input logic [DATA_W-1:0] fwd,
                                input logic [DATA_W-1:0] lat,
                                input logic [DATA_W-1:0] yaw);
        @(negedge clk);
        while (src_idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.vel_fwd  <= fwd;
        cmd_bus.vel_lat  <= lat;
        cmd_bus.yaw_rate <= yaw;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        shaped_q.push_back(shape_command(fwd, lat, yaw));
        commands_sent++;
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (shaped_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        int c;
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            REG_DRIVE_MODE:
            begin
                if (data[MODE_W-1:0] != MODE_INVALID)
                    mode_q = data[MODE_W-1:0];
            end
            REG_CENTER_X:
            begin
                c = $signed(data);
                if (c > CENTER_LIMIT)
                    c = CENTER_LIMIT;
                if (c < -CENTER_LIMIT)
                    c = -CENTER_LIMIT;
                center_q = c[CTR_W-1:0];
            end
            REG_MIN_RADIUS:
            begin
                radius_q = data[RAD_W-1:0];
            end
            default:
            begin
            end
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_velocity();
        logic [DATA_W-1:0] v;
        case ($urandom_range(9))
            0, 1: v = $urandom;
            2: v = '0;
            3:
            begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0001;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            4, 5: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: v = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        endcase
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_center();
        int c;
        case ($urandom_range(5))
            0, 1: c = $urandom;
            2: c = CENTER_LIMIT;
            3: c = -CENTER_LIMIT;
            4: c = $urandom_range(0, 131072) - 65536;
            default: c = 0;
        endcase
        return c[CFG_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] pick_radius();
        logic [CFG_W-1:0] r;
        case ($urandom_range(9))
            0: r = '0;
            1: r = 19'd1;
            2: r = CFG_W'(RADIUS_RESET);
            3: r = 19'd131072;
            4: r = 19'h3FFFF;
            5, 6, 7: r = CFG_W'($urandom);
            default: r = CFG_W'($urandom_range(1, 131072));
        endcase
        return r;
    endfunction

    // result checker: each transfer against the oldest prediction
    always @(posedge clk)
    begin
        dmvs_res_t exp_r;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (shaped_q.size() == 0)
            begin
                note_failure($sformatf("result with nothing pending: fwd %h lat %h yaw %h",
                                       res_bus.out_fwd, res_bus.out_lat, res_bus.out_yaw));
            end
            else
            begin
                exp_r = shaped_q.pop_front();
                results_checked++;
                if (res_bus.out_fwd !== exp_r.fwd)
                    note_failure($sformatf("out_fwd expected %h got %h",
                                           exp_r.fwd, res_bus.out_fwd));
                if (res_bus.out_lat !== exp_r.lat)
                    note_failure($sformatf("out_lat expected %h got %h",
                                           exp_r.lat, res_bus.out_lat));
                if (res_bus.out_yaw !== exp_r.yaw)
                    note_failure($sformatf("out_yaw expected %h got %h",
                                           exp_r.yaw, res_bus.out_yaw));
            end
        end
    end

    // receiver: random idling plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            res_bus.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            res_bus.ready <= !(sink_idle_en && $urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles, %0d results pending",
                         STALL_LIMIT, shaped_q.size());
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // reset values: differential mode, zero center, so lateral is always zero
    task automatic test_register_defaults();
        send_command(32'h0005_0000, 32'h1234_5678, 32'h0000_0000);
        send_command(32'hFFF0_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_command(32'h0000_0001, 32'h8000_0000, 32'h0001_0000);
        settle();
    endtask

    task automatic test_corner_cases();
        write_register(REG_DRIVE_MODE, CFG_W'(MODE_OMNI));
        send_command(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_command(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        settle();
        // invalid mode is dropped, block stays omnidirectional
        write_register(REG_DRIVE_MODE, CFG_W'(MODE_INVALID));
        send_command(32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
        settle();

        write_register(REG_DRIVE_MODE, CFG_W'(MODE_DIFF));
        write_register(REG_CENTER_X, 19'h3FFFF);
        send_command(32'h0005_0000, 32'h0000_0007, 32'h0000_0000);
        send_command(32'h0001_0000, 32'h0000_0000, 32'h8000_0000);
        send_command(32'h0001_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_command(32'h0001_0000, 32'h0000_0000, 32'h0000_0001);
        send_command(32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFD);
        settle();
        write_register(REG_CENTER_X, 19'h40000);
        write_register(REG_SPARE, 19'h7FFFF);
        send_command(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
        settle();

        write_register(REG_DRIVE_MODE, CFG_W'(MODE_ACK));
        write_register(REG_CENTER_X, 19'h00001);
        send_command(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        send_command(32'h0001_0000, 32'h0000_0000, 32'h000A_0000);
        send_command(32'hFFFF_0000, 32'h0000_0000, 32'hFFF6_0000);
        send_command(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
        send_command(32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
        settle();
        write_register(REG_MIN_RADIUS, 19'd0);
        send_command(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        settle();
        write_register(REG_MIN_RADIUS, 19'h3FFFF);
        send_command(32'h0001_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_command(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001);
        settle();
        write_register(REG_MIN_RADIUS, 19'd1);
        send_command(32'h0000_0001, 32'h0000_0000, 32'h8000_0000);
        settle();
    endtask

    // receiver holds off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        write_register(REG_DRIVE_MODE, CFG_W'(MODE_ACK));
        write_register(REG_CENTER_X, pick_center());
        write_register(REG_MIN_RADIUS, CFG_W'(RADIUS_RESET));
        src_idle_en = 1'b0;
        hold_request = 1'b1;
        repeat (100)
            send_command(pick_velocity(), pick_velocity(), pick_velocity());
        src_idle_en = 1'b1;
        settle();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
            begin
                write_register(REG_DRIVE_MODE, CFG_W'(MODE_ACK));
                write_register(REG_CENTER_X, CENTER_LIMIT);
                write_register(REG_MIN_RADIUS, 19'h3FFFF);
            end
            else if (phase == 1)
            begin
                write_register(REG_DRIVE_MODE, CFG_W'(MODE_DIFF));
                write_register(REG_CENTER_X, -CENTER_LIMIT);
                write_register(REG_MIN_RADIUS, 19'd1);
            end
            else
            begin
                write_register(REG_DRIVE_MODE, CFG_W'($urandom_range(0, 3)));
                write_register(REG_CENTER_X, pick_center());
                write_register(REG_MIN_RADIUS, pick_radius());
                if ($urandom_range(3) == 0)
                    write_register(REG_SPARE, CFG_W'($urandom));
            end
            // one phase runs at full rate on both sides
            src_idle_en  = (phase != 4);
            sink_idle_en = (phase != 4);
            repeat (PHASE_ITEMS)
                send_command(pick_velocity(), pick_velocity(), pick_velocity());
            settle();
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.vel_fwd  = '0;
        cmd_bus.vel_lat  = '0;
        cmd_bus.yaw_rate = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = REG_DRIVE_MODE;
        cfg_bus.data     = '0;
        res_bus.ready    = 1'b0;
        mode_q       = MODE_DIFF;
        center_q     = '0;
        radius_q     = RADIUS_RESET;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        hold_request = 1'b0;
        hold_left    = 0;
        stall_cycles = 0;
        fail_count   = 0;
        commands_sent   = 0;
        results_checked = 0;
        cfg_writes      = 0;
        clip_count      = 0;
        lat_sat_count   = 0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_defaults();
        test_corner_cases();
        test_backpressure();
        test_random_traffic();

        settle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (shaped_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", shaped_q.size()));

        $display("run: %0d commands, %0d results checked, %0d register writes",
                 commands_sent, results_checked, cfg_writes);
        $display("run: %0d ackermann yaw clips, %0d saturated lateral outputs, %0d failures",
                 clip_count, lat_sat_count, fail_count);
        if (fail_count == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// File: drive_mode_velocity_shaper.f
+incdir+hw/rtl
hw/rtl/dmvs_pkg.sv
hw/rtl/dmvs_cmd_if.sv
hw/rtl/dmvs_res_if.sv
hw/rtl/dmvs_cfg_if.sv
hw/rtl/dmvs_cfg_regs.sv
hw/rtl/dmvs_front.sv
hw/rtl/dmvs_div_stage.sv
hw/rtl/dmvs_back.sv
hw/rtl/drive_mode_velocity_shaper.sv
tb/testbench.sv
